@@ hw/rtl/rlsmr_pkg.sv @@
// Shared types and constants of the motor resistance/inductance estimator.
// No dependencies; imported by the multiplier, the divider and the top level.
`timescale 1ns / 1ps

package rlsmr_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_RESET_COV = 2'd1,
    CMD_RELOAD    = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RES_SEED = 3'd0,
    REG_IND_SEED = 3'd1,
    REG_LAMBDA   = 3'd2,
    REG_MIN_CONF = 3'd3,
    REG_MIN_EXC  = 3'd4
  } cfg_reg_t;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [30:0] RES_SEED_RST = 31'd16777216;
  localparam logic [30:0] IND_SEED_RST = 31'd16777;
  localparam logic [31:0] LAMBDA_RST   = 32'd2145336164;
  localparam logic [15:0] MIN_CONF_RST = 16'd32768;
  localparam logic [30:0] MIN_EXC_RST  = 31'd25600;

  localparam logic [31:0] LAMBDA_MIN = 32'h4000_0000;
  localparam logic [31:0] LAMBDA_MAX = 32'h8000_0000;

  localparam logic signed [47:0] COV_ONE       = 48'sh0001_0000_0000;
  localparam logic signed [48:0] TRACE_LIMIT   = 49'sd429496730;
  localparam logic signed [63:0] INV_SQRT3_Q31 = 64'sd1239850262;
  localparam logic [7:0] CONVERGE_UPDATES = 8'd100;
  localparam logic [7:0] VALID_UPDATES    = 8'd10;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

endpackage

@@ hw/rtl/rls_motor_resistance_inductance.sv @@
// Motor resistance and inductance estimator by two-parameter recursive least
// squares with a forgetting factor. Commands other than a sample, and a sample
// that fails the confidence gate, go straight to the output state. One that
// passes is worked by a sequencer over one shared multiplier and one
// bit-serial divider: an excitation gate, then two updates of six divisions
// each. in_ready is low while an item is in work; a finished result waits in
// the output register.
// Depends on rlsmr_pkg, rlsmr_mul and rlsmr_div.
`timescale 1ns / 1ps

module rls_motor_resistance_inductance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_volt_alpha,
  input  logic signed [31:0] in_volt_beta,
  input  logic signed [31:0] in_emf_alpha,
  input  logic signed [31:0] in_emf_beta,
  input  logic signed [31:0] in_amp_alpha,
  input  logic signed [31:0] in_amp_beta,
  input  logic signed [31:0] in_slope_u,
  input  logic signed [31:0] in_slope_v,
  input  logic [15:0]        in_confidence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_resistance_estimate,
  output logic signed [31:0] out_inductance_estimate,
  output logic               out_estimates_valid,
  output logic               out_converged,
  output logic               out_sample_used
);
  import rlsmr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DB, ST_A2, ST_B2, ST_THR,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_D1, ST_D2, ST_M9, ST_M10, ST_ERR, ST_M11, ST_M12,
    ST_M13, ST_D3, ST_M14, ST_D4, ST_M15, ST_D5, ST_M16, ST_D6,
    ST_TRACE, ST_OUT
  } state_t;

  // Configuration
  logic [30:0] res_seed_r, ind_seed_r, min_exc_r;
  logic [31:0] lambda_cfg_r;
  logic [15:0] min_conf_r;

  // Estimator state
  logic signed [31:0] th_r_r, th_l_r;
  logic signed [47:0] p00_r, p01_r, p10_r, p11_r;
  logic [7:0]         cnt_r;
  logic               conv_r;

  // Item work registers
  state_t             state_r;
  logic               issued_r, eq_r, used_r;
  logic signed [31:0] amp_a_r, amp_b_r, da_r, db_r, ya_r, yb_r;
  logic signed [33:0] sum_r;
  logic [31:0]        lam_r;
  logic signed [63:0] tmp_r, v0_r, v1_r, w0_r, w1_r, den_r, k0_r, k1_r, err_r;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_res_r, out_ind_r;
  logic               out_ev_r, out_conv_r, out_used_r;

  // Shared units
  logic               mul_go, div_go, mul_start, div_start, mul_done, div_done;
  logic signed [63:0] mul_a, mul_b, div_num, mul_res, div_res;
  logic [63:0]        div_den;
  logic [5:0]         mul_sh, div_sh;

  logic signed [31:0] ph0, ph1, y_w;
  logic signed [63:0] ph0_64, ph1_64, lam2_64;
  logic [63:0]        lam_64;
  logic signed [32:0] dya, dyb;
  logic signed [48:0] trace_w;
  logic [63:0]        e2_sum;
  logic               in_acc;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (x < 64'shFFFF_8000_0000_0000) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic logic signed [31:0] th_add(input logic signed [31:0] th,
                                                input logic signed [63:0] m);
    logic signed [64:0] s;
    s = 65'(th) + 65'(m);
    if (s > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -65'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    ph0     = eq_r ? amp_b_r : amp_a_r;
    ph1     = eq_r ? db_r : da_r;
    y_w     = eq_r ? yb_r : ya_r;
    ph0_64  = 64'(ph0);
    ph1_64  = 64'(ph1);
    lam_64  = {32'b0, lam_r};
    lam2_64 = $signed({31'b0, lam_r, 1'b0});
    dya     = 33'(in_volt_alpha) - 33'(in_emf_alpha);
    dyb     = 33'(in_volt_beta) - 33'(in_emf_beta);
    trace_w = 49'(p00_r) + 49'(p11_r);
    e2_sum  = tmp_r + mul_res;
  end

  // Operand selection for the shared units
  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = 6'd0;
    div_num = '0;
    div_den = den_r;
    div_sh  = 6'd32;
    unique case (state_r)
      ST_DB:  begin mul_go = 1'b1; mul_a = 64'(sum_r); mul_b = INV_SQRT3_Q31; mul_sh = 6'd31; end
      ST_A2:  begin mul_go = 1'b1; mul_a = 64'(da_r); mul_b = 64'(da_r); end
      ST_B2:  begin mul_go = 1'b1; mul_a = 64'(db_r); mul_b = 64'(db_r); end
      ST_THR: begin
        mul_go = 1'b1;
        mul_a  = $signed({33'b0, min_exc_r});
        mul_b  = $signed({33'b0, min_exc_r});
      end
      ST_M1:  begin mul_go = 1'b1; mul_a = 64'(p00_r); mul_b = ph0_64; mul_sh = 6'd16; end
      ST_M2:  begin mul_go = 1'b1; mul_a = 64'(p10_r); mul_b = ph1_64; mul_sh = 6'd8; end
      ST_M3:  begin mul_go = 1'b1; mul_a = 64'(p01_r); mul_b = ph1_64; mul_sh = 6'd8; end
      ST_M4:  begin mul_go = 1'b1; mul_a = 64'(p11_r); mul_b = ph1_64; mul_sh = 6'd8; end
      ST_M5:  begin mul_go = 1'b1; mul_a = 64'(p10_r); mul_b = ph0_64; mul_sh = 6'd16; end
      ST_M6:  begin mul_go = 1'b1; mul_a = 64'(p01_r); mul_b = ph0_64; mul_sh = 6'd16; end
      ST_M7:  begin mul_go = 1'b1; mul_a = ph0_64; mul_b = v0_r; mul_sh = 6'd16; end
      ST_M8:  begin mul_go = 1'b1; mul_a = ph1_64; mul_b = v1_r; mul_sh = 6'd8; end
      ST_D1:  begin div_go = 1'b1; div_num = v0_r; end
      ST_D2:  begin div_go = 1'b1; div_num = v1_r; end
      ST_M9:  begin mul_go = 1'b1; mul_a = ph0_64; mul_b = 64'(th_r_r); mul_sh = 6'd24; end
      ST_M10: begin mul_go = 1'b1; mul_a = ph1_64; mul_b = 64'(th_l_r); mul_sh = 6'd16; end
      ST_M11: begin mul_go = 1'b1; mul_a = k0_r; mul_b = err_r; mul_sh = 6'd24; end
      ST_M12: begin mul_go = 1'b1; mul_a = k1_r; mul_b = err_r; mul_sh = 6'd24; end
      ST_M13: begin mul_go = 1'b1; mul_a = k0_r; mul_b = w0_r; mul_sh = 6'd32; end
      ST_M14: begin mul_go = 1'b1; mul_a = k0_r; mul_b = w1_r; mul_sh = 6'd32; end
      ST_M15: begin mul_go = 1'b1; mul_a = k1_r; mul_b = w0_r; mul_sh = 6'd32; end
      ST_M16: begin mul_go = 1'b1; mul_a = k1_r; mul_b = w1_r; mul_sh = 6'd32; end
      ST_D3, ST_D4, ST_D5, ST_D6: begin
        div_go  = 1'b1;
        div_num = tmp_r;
        div_den = lam_64;
        div_sh  = 6'd31;
      end
      default: ;
    endcase
  end

  assign mul_start = mul_go && !issued_r;
  assign div_start = div_go && !issued_r;

  rlsmr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  rlsmr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .sh    (div_sh),
    .done  (div_done),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_seed_r   <= RES_SEED_RST;
      ind_seed_r   <= IND_SEED_RST;
      lambda_cfg_r <= LAMBDA_RST;
      min_conf_r   <= MIN_CONF_RST;
      min_exc_r    <= MIN_EXC_RST;
      th_r_r       <= $signed({1'b0, RES_SEED_RST});
      th_l_r       <= $signed({1'b0, IND_SEED_RST});
      p00_r        <= COV_ONE;
      p01_r        <= '0;
      p10_r        <= '0;
      p11_r        <= COV_ONE;
      cnt_r        <= '0;
      conv_r       <= 1'b0;
      state_r      <= ST_IDLE;
      issued_r     <= 1'b0;
      eq_r         <= 1'b0;
      used_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RES_SEED: res_seed_r   <= cfg_wdata[30:0];
          REG_IND_SEED: ind_seed_r   <= cfg_wdata[30:0];
          REG_LAMBDA:   lambda_cfg_r <= cfg_wdata;
          REG_MIN_CONF: min_conf_r   <= cfg_wdata[15:0];
          REG_MIN_EXC:  min_exc_r    <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      if (mul_start || div_start) issued_r <= 1'b1;
      if (mul_done || div_done) issued_r <= 1'b0;

      if (out_valid_r && out_ready && state_r != ST_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            amp_a_r <= in_amp_alpha;
            amp_b_r <= in_amp_beta;
            da_r    <= in_slope_u;
            sum_r   <= 34'(in_slope_u) + (34'(in_slope_v) <<< 1);
            ya_r    <= sat32(64'(dya));
            yb_r    <= sat32(64'(dyb));
            if (lambda_cfg_r < LAMBDA_MIN) lam_r <= LAMBDA_MIN;
            else if (lambda_cfg_r > LAMBDA_MAX) lam_r <= LAMBDA_MAX;
            else lam_r <= lambda_cfg_r;
            used_r <= 1'b0;
            eq_r   <= 1'b0;
            state_r <= ST_OUT;
            unique case (cmd_t'(in_command))
              CMD_RESET_COV, CMD_RELOAD: begin
                if (cmd_t'(in_command) == CMD_RELOAD) begin
                  th_r_r <= $signed({1'b0, res_seed_r});
                  th_l_r <= $signed({1'b0, ind_seed_r});
                end
                p00_r  <= COV_ONE;
                p01_r  <= '0;
                p10_r  <= '0;
                p11_r  <= COV_ONE;
                cnt_r  <= '0;
                conv_r <= 1'b0;
              end
              CMD_SAMPLE: begin
                if (in_confidence >= min_conf_r) state_r <= ST_DB;
              end
              default: ;
            endcase
          end
        end
        ST_DB:  if (mul_done) begin db_r <= sat32(mul_res); state_r <= ST_A2; end
        ST_A2:  if (mul_done) begin tmp_r <= mul_res; state_r <= ST_B2; end
        ST_B2:  if (mul_done) begin tmp_r <= $signed(e2_sum); state_r <= ST_THR; end
        ST_THR: begin
          if (mul_done) begin
            // The squared slopes are compared as unsigned words.
            if ($unsigned(tmp_r) >= $unsigned(mul_res)) begin
              used_r  <= 1'b1;
              state_r <= ST_M1;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_M1:  if (mul_done) begin tmp_r <= mul_res; state_r <= ST_M2; end
        ST_M2:  if (mul_done) begin w0_r <= sadd(tmp_r, mul_res); state_r <= ST_M3; end
        ST_M3:  if (mul_done) begin v0_r <= sadd(tmp_r, mul_res); state_r <= ST_M4; end
        ST_M4:  if (mul_done) begin tmp_r <= mul_res; state_r <= ST_M5; end
        ST_M5:  if (mul_done) begin v1_r <= sadd(tmp_r, mul_res); state_r <= ST_M6; end
        ST_M6:  if (mul_done) begin w1_r <= sadd(tmp_r, mul_res); state_r <= ST_M7; end
        ST_M7:  if (mul_done) begin tmp_r <= sadd(lam2_64, mul_res); state_r <= ST_M8; end
        ST_M8: begin
          if (mul_done) begin
            den_r <= sadd(tmp_r, mul_res);
            // A non-positive denominator skips this update entirely.
            if (sadd(tmp_r, mul_res) <= 64'sd0) begin
              if (eq_r) state_r <= ST_TRACE;
              else begin
                eq_r    <= 1'b1;
                state_r <= ST_M1;
              end
            end else begin
              state_r <= ST_D1;
            end
          end
        end
        ST_D1:  if (div_done) begin k0_r <= div_res; state_r <= ST_D2; end
        ST_D2:  if (div_done) begin k1_r <= div_res; state_r <= ST_M9; end
        ST_M9:  if (mul_done) begin tmp_r <= mul_res; state_r <= ST_M10; end
        ST_M10: if (mul_done) begin tmp_r <= sadd(tmp_r, mul_res); state_r <= ST_ERR; end
        ST_ERR: begin
          err_r   <= ssub(64'(y_w), tmp_r);
          state_r <= ST_M11;
        end
        ST_M11: if (mul_done) begin th_r_r <= th_add(th_r_r, mul_res); state_r <= ST_M12; end
        ST_M12: if (mul_done) begin th_l_r <= th_add(th_l_r, mul_res); state_r <= ST_M13; end
        ST_M13: if (mul_done) begin tmp_r <= ssub(64'(p00_r), mul_res); state_r <= ST_D3; end
        ST_D3:  if (div_done) begin p00_r <= sat48(div_res); state_r <= ST_M14; end
        ST_M14: if (mul_done) begin tmp_r <= ssub(64'(p01_r), mul_res); state_r <= ST_D4; end
        ST_D4:  if (div_done) begin p01_r <= sat48(div_res); state_r <= ST_M15; end
        ST_M15: if (mul_done) begin tmp_r <= ssub(64'(p10_r), mul_res); state_r <= ST_D5; end
        ST_D5:  if (div_done) begin p10_r <= sat48(div_res); state_r <= ST_M16; end
        ST_M16: if (mul_done) begin tmp_r <= ssub(64'(p11_r), mul_res); state_r <= ST_D6; end
        ST_D6: begin
          if (div_done) begin
            p11_r <= sat48(div_res);
            if (cnt_r != COUNT_MAX) cnt_r <= cnt_r + 8'd1;
            if (eq_r) state_r <= ST_TRACE;
            else begin
              eq_r    <= 1'b1;
              state_r <= ST_M1;
            end
          end
        end
        ST_TRACE: begin
          if (trace_w < TRACE_LIMIT && cnt_r > CONVERGE_UPDATES) conv_r <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_res_r   <= th_r_r;
            out_ind_r   <= th_l_r;
            out_ev_r    <= (cnt_r > VALID_UPDATES);
            out_conv_r  <= conv_r;
            out_used_r  <= used_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_resistance_estimate = out_res_r;
  assign out_inductance_estimate = out_ind_r;
  assign out_estimates_valid     = out_ev_r;
  assign out_converged           = out_conv_r;
  assign out_sample_used         = out_used_r;

endmodule

@@ hw/rtl/rlsmr_mul.sv @@
// Multi-cycle signed 64x64 multiplier with rounded right shift and saturation.
// One 32x32 partial product per cycle; uses rlsmr_pkg.
`timescale 1ns / 1ps

module rlsmr_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [5:0]         sh,
  output logic               done,
  output logic signed [63:0] res
);
  import rlsmr_pkg::*;

  typedef enum logic [1:0] {MS_IDLE, MS_ACC, MS_RND, MS_FIN} mstate_t;

  mstate_t            state_r;
  logic [63:0]        ua_r, ub_r;
  logic               neg_r;
  logic [5:0]         sh_r;
  logic [127:0]       acc_r;
  logic [1:0]         cnt_r;
  logic               done_r;
  logic signed [63:0] res_r;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] pp_sh, rnd, shifted;
  logic [63:0]  mag_q;

  always_comb begin
    pa      = cnt_r[0] ? ua_r[63:32] : ua_r[31:0];
    pb      = cnt_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp      = pa * pb;
    pos     = 2'(cnt_r[0]) + 2'(cnt_r[1]);
    pp_sh   = 128'(pp) << {pos, 5'b0};
    rnd     = (128'(1) << sh_r) >> 1;
    shifted = acc_r >> sh_r;
    mag_q   = (shifted[127:63] != '0) ? 64'(S64_MAX) : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MS_IDLE: begin
          if (start) begin
            ua_r    <= a[63] ? 64'(-a) : 64'(a);
            ub_r    <= b[63] ? 64'(-b) : 64'(b);
            neg_r   <= a[63] ^ b[63];
            sh_r    <= sh;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= MS_ACC;
          end
        end
        MS_ACC: begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= MS_RND;
        end
        MS_RND: begin
          acc_r   <= acc_r + rnd;
          state_r <= MS_FIN;
        end
        MS_FIN: begin
          res_r   <= neg_r ? -$signed(mag_q) : $signed(mag_q);
          done_r  <= 1'b1;
          state_r <= MS_IDLE;
        end
        default: state_r <= MS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ hw/rtl/rlsmr_div.sv @@
// Bit-serial restoring divider: trunc(num * 2^sh / den) with saturation, den > 0.
// One quotient bit per cycle, 96 steps; uses rlsmr_pkg.
`timescale 1ns / 1ps

module rlsmr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        den,
  input  logic [5:0]         sh,
  output logic               done,
  output logic signed [63:0] res
);
  import rlsmr_pkg::*;

  localparam int DIV_STEPS = 96;

  typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_FIN} dstate_t;

  dstate_t            state_r;
  logic [95:0]        n_r;
  logic [63:0]        rem_r, q_r, den_r;
  logic               ovf_r, neg_r;
  logic [6:0]         cnt_r;
  logic               done_r;
  logic signed [63:0] res_r;

  logic [64:0] r_sh, r_sub;
  logic        ge;
  logic [63:0] mag_q;

  always_comb begin
    r_sh  = {rem_r, n_r[95]};
    r_sub = r_sh - {1'b0, den_r};
    ge    = (r_sh >= {1'b0, den_r});
    mag_q = (ovf_r || q_r[63]) ? 64'(S64_MAX) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DS_IDLE: begin
          if (start) begin
            n_r     <= 96'(num[63] ? 64'(-num) : 64'(num)) << sh;
            neg_r   <= num[63];
            den_r   <= den;
            rem_r   <= '0;
            q_r     <= '0;
            ovf_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= DS_RUN;
          end
        end
        DS_RUN: begin
          // Remainder stays below the divisor, so 64 bits hold it.
          rem_r <= ge ? r_sub[63:0] : r_sh[63:0];
          q_r   <= {q_r[62:0], ge};
          ovf_r <= ovf_r | q_r[63];
          n_r   <= n_r << 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) state_r <= DS_FIN;
        end
        DS_FIN: begin
          res_r   <= neg_r ? -$signed(mag_q) : $signed(mag_q);
          done_r  <= 1'b1;
          state_r <= DS_IDLE;
        end
        default: state_r <= DS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ verif/tb_rls_motor_resistance_inductance.sv @@
// Self-checking testbench of the RLS motor resistance/inductance estimator.
// Holds a bit-exact fixed-point predictor; depends on rlsmr_pkg and the top level.
`timescale 1ns / 1ps

module tb_rls_motor_resistance_inductance;
  import rlsmr_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    cmd_t              command;
    logic signed [31:0] va, vb, ea, eb, ia, ib, su, sv;
    logic [15:0]       conf;
  } sample_t;

  typedef struct {
    logic signed [31:0] res, ind;
    logic              valid, conv, used;
  } estimate_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_command = '0;
  logic signed [31:0] in_volt_alpha = '0, in_volt_beta = '0, in_emf_alpha = '0;
  logic signed [31:0] in_emf_beta = '0, in_amp_alpha = '0, in_amp_beta = '0;
  logic signed [31:0] in_slope_u = '0, in_slope_v = '0;
  logic [15:0] in_confidence = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] out_resistance_estimate, out_inductance_estimate;
  logic out_estimates_valid, out_converged, out_sample_used;

  rls_motor_resistance_inductance DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the configuration and the estimator state.
  logic [30:0] seed_r, seed_l, exc_min;
  logic [31:0] lambda_reg;
  logic [15:0] conf_min;
  logic signed [63:0] th_r, th_l;
  logic signed [63:0] cov [4];
  int unsigned upd_cnt;
  bit conv_flag;

  sample_t   pending [$];
  estimate_t expected_est [$];
  int in_idle_pct, out_idle_pct;
  bit in_fire;
  int errors, n_results, n_used, n_conv;

  function automatic logic [63:0] magn(input logic signed [63:0] a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sat_to(input logic signed [63:0] x, input int bits);
    logic signed [63:0] lim;
    lim = (64'sd1 <<< (bits - 1)) - 64'sd1;
    if (x > lim) return lim;
    if (x < -lim - 64'sd1) return -lim - 64'sd1;
    return x;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > S64_MAX) return S64_MAX;
    if (s < S64_MIN) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s > S64_MAX) return S64_MAX;
    if (s < S64_MIN) return S64_MIN;
    return s[63:0];
  endfunction

  // Product scaled down by 2^sh, rounded half away from zero.
  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a, b,
                                                   input int sh);
    logic [127:0] p;
    logic neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  // Quotient of num * 2^sh by a positive den, truncated toward zero.
  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] num, den,
                                                   input int sh);
    logic [127:0] q;
    q = ({64'd0, magn(num)} << sh) / {64'd0, den};
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
    return num < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic void rls_update(input logic signed [63:0] ph0, ph1, y, lam);
    logic signed [63:0] v0, v1, w0, w1, den, k0, k1, err;
    logic signed [63:0] p00, p01, p10, p11;
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    v0 = add_sat(mul_round(p00, ph0, 16), mul_round(p01, ph1, 8));
    v1 = add_sat(mul_round(p10, ph0, 16), mul_round(p11, ph1, 8));
    w0 = add_sat(mul_round(p00, ph0, 16), mul_round(p10, ph1, 8));
    w1 = add_sat(mul_round(p01, ph0, 16), mul_round(p11, ph1, 8));
    den = add_sat(add_sat(lam * 2, mul_round(ph0, v0, 16)), mul_round(ph1, v1, 8));
    if (den <= 0) return;
    k0 = div_trunc(v0, den, 32);
    k1 = div_trunc(v1, den, 32);
    err = sub_sat(y, add_sat(mul_round(ph0, th_r, 24), mul_round(ph1, th_l, 16)));
    th_r = sat_to(add_sat(th_r, mul_round(k0, err, 24)), 32);
    th_l = sat_to(add_sat(th_l, mul_round(k1, err, 24)), 32);
    cov[0] = sat_to(div_trunc(sub_sat(p00, mul_round(k0, w0, 32)), lam, 31), 48);
    cov[1] = sat_to(div_trunc(sub_sat(p01, mul_round(k0, w1, 32)), lam, 31), 48);
    cov[2] = sat_to(div_trunc(sub_sat(p10, mul_round(k1, w0, 32)), lam, 31), 48);
    cov[3] = sat_to(div_trunc(sub_sat(p11, mul_round(k1, w1, 32)), lam, 31), 48);
    if (upd_cnt < 255) upd_cnt++;
  endfunction

  function automatic void clear_covariance();
    cov[0] = COV_ONE; cov[1] = 0; cov[2] = 0; cov[3] = COV_ONE;
    upd_cnt = 0;
    conv_flag = 1'b0;
  endfunction

  function automatic estimate_t estimate_step(input sample_t s);
    estimate_t e;
    logic signed [63:0] su, sv, sum, da, db, ya, yb;
    logic [127:0] q;
    logic [64:0] e2;
    logic [63:0] thr;
    logic [31:0] lam;
    e.used = 1'b0;
    if (s.command == CMD_RESET_COV) begin
      clear_covariance();
    end else if (s.command == CMD_RELOAD) begin
      th_r = seed_r;
      th_l = seed_l;
      clear_covariance();
    end else if (s.command == CMD_SAMPLE && s.conf >= conf_min) begin
      su = s.su;
      sv = s.sv;
      sum = su + 2 * sv;
      q = ({64'd0, magn(sum)} * 128'(INV_SQRT3_Q31) + (128'd1 << 30)) >> 31;
      da = sat_to(su, 32);
      db = sat_to(sum < 0 ? -$signed(q[63:0]) : $signed(q[63:0]), 32);
      e2 = {1'b0, magn(da) * magn(da)} + {1'b0, magn(db) * magn(db)};
      if (e2[64]) e2 = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      thr = 64'(exc_min) * 64'(exc_min);
      if (e2[63:0] >= thr) begin
        lam = lambda_reg;
        if (lam < LAMBDA_MIN) lam = LAMBDA_MIN;
        if (lam > LAMBDA_MAX) lam = LAMBDA_MAX;
        ya = sat_to(64'(s.va) - 64'(s.ea), 32);
        yb = sat_to(64'(s.vb) - 64'(s.eb), 32);
        e.used = 1'b1;
        rls_update(64'(s.ia), da, ya, 64'(lam));
        rls_update(64'(s.ib), db, yb, 64'(lam));
        if (add_sat(cov[0], cov[3]) < TRACE_LIMIT && upd_cnt > CONVERGE_UPDATES)
          conv_flag = 1'b1;
      end
    end
    e.res = sat_to(th_r, 32);
    e.ind = sat_to(th_l, 32);
    e.valid = upd_cnt > VALID_UPDATES;
    e.conv = conv_flag;
    return e;
  endfunction

  // Samples that follow v = R*i + L*di/dt with R = 0.5 ohm and L = 1 mH.
  function automatic sample_t plausible_sample();
    sample_t s;
    logic signed [63:0] bslope;
    s.command = CMD_SAMPLE;
    s.ia = $signed(32'($urandom_range(1310720))) - 655360;
    s.ib = $signed(32'($urandom_range(1310720))) - 655360;
    s.su = $signed(32'($urandom_range(51200000))) - 25600000;
    s.sv = $signed(32'($urandom_range(51200000))) - 25600000;
    s.ea = $signed(32'($urandom_range(131072))) - 65536;
    s.eb = $signed(32'($urandom_range(131072))) - 65536;
    bslope = ((64'(s.su) + 2 * 64'(s.sv)) * 64'sd1239850262) >>> 31;
    s.va = 32'((64'(s.ia) >>> 1) + 64'(s.su) * 64'sd256 / 64'sd1000 + 64'(s.ea)
               + $signed(64'($urandom_range(64))) - 64'sd32);
    s.vb = 32'((64'(s.ib) >>> 1) + bslope * 64'sd256 / 64'sd1000 + 64'(s.eb)
               + $signed(64'($urandom_range(64))) - 64'sd32);
    s.conf = 16'($urandom_range(65535, conf_min));
    return s;
  endfunction

  function automatic sample_t random_sample(input bit samples_only);
    sample_t s;
    int r;
    r = $urandom_range(99);
    if (samples_only && r < 85) return plausible_sample();
    if (!samples_only && r >= 35) return plausible_sample();
    s.va = $urandom; s.vb = $urandom; s.ea = $urandom; s.eb = $urandom;
    s.ia = $urandom; s.ib = $urandom; s.su = $urandom; s.sv = $urandom;
    s.conf = 16'($urandom);
    if (r < 6) s.command = CMD_NONE;
    else if (r < 14 && !samples_only) s.command = CMD_RESET_COV;
    else if (r < 20 && !samples_only) s.command = CMD_RELOAD;
    else s.command = CMD_SAMPLE;
    return s;
  endfunction

  function automatic sample_t directed(input cmd_t c, input logic signed [31:0] v,
                                       input logic signed [31:0] i,
                                       input logic signed [31:0] su, sv,
                                       input logic [15:0] conf);
    sample_t s;
    s.command = c;
    s.va = v; s.vb = -v; s.ea = -v; s.eb = v;
    s.ia = i; s.ib = -i; s.su = su; s.sv = sv;
    s.conf = conf;
    return s;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_RES_SEED: seed_r = data[30:0];
      REG_IND_SEED: seed_l = data[30:0];
      REG_LAMBDA:   lambda_reg = data;
      REG_MIN_CONF: conf_min = data[15:0];
      REG_MIN_EXC:  exc_min = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] rs, ls, lam, conf, exc);
    write_reg(REG_RES_SEED, rs);
    write_reg(REG_IND_SEED, ls);
    write_reg(REG_LAMBDA, lam);
    write_reg(REG_MIN_CONF, conf);
    write_reg(REG_MIN_EXC, exc);
  endtask

  task automatic drain();
    while (pending.size() != 0 || expected_est.size() != 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_random(input int count, input bit samples_only);
    sample_t s;
    s = directed(CMD_RELOAD, 0, 0, 0, 0, 0);
    pending.push_back(s);
    repeat (count) pending.push_back(random_sample(samples_only));
  endtask

  // Input item driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          sample_t s;
          s = pending.pop_front();
          in_valid <= 1'b1;
          in_command <= s.command;
          in_volt_alpha <= s.va; in_volt_beta <= s.vb;
          in_emf_alpha <= s.ea;  in_emf_beta <= s.eb;
          in_amp_alpha <= s.ia;  in_amp_beta <= s.ib;
          in_slope_u <= s.su;    in_slope_v <= s.sv;
          in_confidence <= s.conf;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(99) >= out_idle_pct;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      sample_t s;
      s.command = cmd_t'(in_command);
      s.va = in_volt_alpha; s.vb = in_volt_beta;
      s.ea = in_emf_alpha;  s.eb = in_emf_beta;
      s.ia = in_amp_alpha;  s.ib = in_amp_beta;
      s.su = in_slope_u;    s.sv = in_slope_v;
      s.conf = in_confidence;
      expected_est.push_back(estimate_step(s));
    end
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_est.size() == 0) begin
        $display("%0t: result with no item pending: res %h ind %h", $realtime,
                 out_resistance_estimate, out_inductance_estimate);
        errors++;
      end else begin
        estimate_t e;
        e = expected_est.pop_front();
        if (out_sample_used) n_used++;
        if (out_converged) n_conv++;
        if (out_resistance_estimate !== e.res) begin
          $display("%0t: resistance expected %h actual %h", $realtime, e.res,
                   out_resistance_estimate);
          errors++;
        end
        if (out_inductance_estimate !== e.ind) begin
          $display("%0t: inductance expected %h actual %h", $realtime, e.ind,
                   out_inductance_estimate);
          errors++;
        end
        if (out_estimates_valid !== e.valid) begin
          $display("%0t: estimates_valid expected %b actual %b", $realtime, e.valid,
                   out_estimates_valid);
          errors++;
        end
        if (out_converged !== e.conv) begin
          $display("%0t: converged expected %b actual %b", $realtime, e.conv,
                   out_converged);
          errors++;
        end
        if (out_sample_used !== e.used) begin
          $display("%0t: sample_used expected %b actual %b", $realtime, e.used,
                   out_sample_used);
          errors++;
        end
      end
    end
  end

  initial begin
    #300_000_000;
    $display("tb_rls_motor_resistance_inductance failed");
    $finish;
  end

  initial begin
    seed_r = RES_SEED_RST; seed_l = IND_SEED_RST; lambda_reg = LAMBDA_RST;
    conf_min = MIN_CONF_RST; exc_min = MIN_EXC_RST;
    th_r = RES_SEED_RST; th_l = IND_SEED_RST;
    clear_covariance();
    errors = 0; n_results = 0; n_used = 0; n_conv = 0;
    in_idle_pct = 16; out_idle_pct = 57;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: gate edges, field extremes and every command.
    pending.push_back(directed(CMD_SAMPLE, 32'sd65536, 32'sd65536, 32'sd25600, -32'sd12800,
                               16'd32768));
    pending.push_back(directed(CMD_SAMPLE, 32'sd65536, 32'sd65536, 32'sd25599, -32'sd12800,
                               16'd32768));
    pending.push_back(directed(CMD_SAMPLE, 32'sd65536, 32'sd65536, 32'sd900000, 32'sd5,
                               16'd32767));
    pending.push_back(directed(CMD_SAMPLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF));
    pending.push_back(directed(CMD_SAMPLE, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000, 16'hFFFF));
    pending.push_back(directed(CMD_SAMPLE, 0, 0, 0, 0, 16'hFFFF));
    pending.push_back(directed(CMD_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh7FFF_FFFF, 16'h8000));
    pending.push_back(directed(CMD_NONE, 32'sh7FFF_FFFF, 32'sd65536, 32'sd900000, 0,
                               16'hFFFF));
    pending.push_back(directed(CMD_RESET_COV, 0, 0, 0, 0, 0));
    pending.push_back(directed(CMD_SAMPLE, 32'sd300000, 32'sd200000, -32'sd2000000,
                               32'sd700000, 16'hC000));
    pending.push_back(directed(CMD_RELOAD, 0, 0, 0, 0, 0));
    repeat (12) pending.push_back(plausible_sample());
    drain();

    configure(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    queue_random(300, 1'b0);
    drain();

    configure(32'h0080_0000, 32'h0000_4000, LAMBDA_MAX, 32'd16384, 32'd25600);
    queue_random(400, 1'b1);
    drain();

    in_idle_pct = 57; out_idle_pct = 16;
    configure(32'h0100_0000, 32'h0000_0100, 32'hFFFF_FFFF, 32'd65535, 32'h7FFF_FFFF);
    queue_random(200, 1'b0);
    drain();

    configure(32'h0100_0000, 32'h0000_4189, 32'h7F00_0000, 32'd100, 32'd1000);
    queue_random(250, 1'b0);
    drain();
    queue_random(250, 1'b0);
    drain();

    in_idle_pct = 0; out_idle_pct = 0;
    configure(32'h0000_0001, 32'h7FFF_FFFF, LAMBDA_MIN, 32'd0, 32'd256);
    queue_random(500, 1'b1);
    drain();
    repeat (50) @(posedge clk);

    $display("Checked %0d estimates; %0d samples took the RLS update, %0d reported converged.",
             n_results, n_used, n_conv);
    if (errors == 0) begin
      $display("tb_rls_motor_resistance_inductance passed");
    end else begin
      $display("tb_rls_motor_resistance_inductance failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rlsmr_pkg.sv
hw/rtl/rlsmr_mul.sv
hw/rtl/rlsmr_div.sv
hw/rtl/rls_motor_resistance_inductance.sv
verif/tb_rls_motor_resistance_inductance.sv
